// ----- hw/rtl/m3sh_pkg.sv -----
package m3sh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NbW    = 3;
  localparam int unsigned ApbAw  = 3;

  localparam logic [WordW-1:0] MixC1   = 32'hcc9e2d51;
  localparam logic [WordW-1:0] MixC2   = 32'h1b873593;
  localparam logic [WordW-1:0] MixAddH = 32'he6546b64;
  localparam logic [WordW-1:0] FinM1   = 32'h85ebca6b;
  localparam logic [WordW-1:0] FinM2   = 32'hc2b2ae35;
  localparam int unsigned      MixRotK = 15;
  localparam int unsigned      MixRotH = 13;

  localparam logic [NbW-1:0] NbFull = 3'd4;

  typedef enum logic [0:0] {
    REG_HASH_SEED = 1'b0,
    REG_NONE      = 1'b1
  } m3sh_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCRAM = 6'b000010,
    ST_MIX   = 6'b000100,
    ST_FIN1  = 6'b001000,
    ST_FIN2  = 6'b010000,
    ST_EMIT  = 6'b100000
  } m3sh_state_e;

  typedef struct packed {
    logic load;
    logic scramble;
    logic mix;
    logic fin1;
    logic fin2;
    logic emit;
  } m3sh_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } m3sh_status_t;

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x,
                                              input int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic logic [WordW-1:0] tail_mask(input logic [NbW-1:0] nb);
    logic [WordW-1:0] m;
    case (nb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/m3sh_in_if.sv -----
interface m3sh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

// ----- hw/rtl/m3sh_out_if.sv -----
interface m3sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ----- hw/rtl/murmur3_stream_hasher.sv -----
// MurmurHash3 x86 32-bit hasher for keys streamed as little-endian 32-bit words.
// Key words enter on key_i; the first key byte sits in data_word[7:0]. A word
// with last_word low always counts four bytes. The last word carries 0 to 4
// valid bytes in valid_bytes (values above 4 count as 4).
// The finished hash leaves on hash_o, one transaction per key, from a result
// register; the next key is taken in while that result still waits.
// Inside a key the next word is accepted during the mix of the previous one,
// after the second scramble multiply. The last word holds the block through
// scramble, mix and both finaliser steps until its hash is emitted into the
// result register. The single shared 32x32 multiplier, used in turn by the
// scramble and both finaliser steps, is why these steps run one after another.
// If the receiver stalls with a result still pending, the next finished hash
// waits in the finaliser and key_i is held off until the result is taken.
// The seed is written over the APB port at byte addresses 0 to 3 (paddr[2]
// low) and is sampled on the first word of each key. Reset clears the seed
// to zero, drops any key in progress and empties the result register.
module murmur3_stream_hasher
  import m3sh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  m3sh_in_if.sink          key_i,
  m3sh_out_if.source       hash_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [WordW-1:0] pwdata,
  output logic [WordW-1:0] prdata,
  output logic             pready
);

  logic [WordW-1:0] seed_q, seed_d;
  logic             reg_sel;
  m3sh_cmd_t        cmd;
  m3sh_status_t     status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_HASH_SEED);
  assign prdata  = reg_sel ? seed_q : '0;

  always_comb begin
    seed_d = seed_q;
    if (psel && penable && pwrite && reg_sel) begin
      seed_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  m3sh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (key_i.valid),
    .in_ready_o (key_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  m3sh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .seed_i        (seed_q),
    .data_word_i   (key_i.data_word),
    .valid_bytes_i (key_i.valid_bytes),
    .last_word_i   (key_i.last_word),
    .out_valid_o   (hash_o.valid),
    .out_ready_i   (hash_o.ready),
    .hash_value_o  (hash_o.hash_value)
  );

endmodule

// ----- hw/rtl/m3sh_datapath.sv -----
module m3sh_datapath
  import m3sh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  m3sh_cmd_t            cmd_i,
  output m3sh_status_t         status_o,
  input  logic [WordW-1:0]     seed_i,
  input  logic [WordW-1:0]     data_word_i,
  input  logic [NbW-1:0]       valid_bytes_i,
  input  logic                 last_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WordW-1:0]     hash_value_o
);

  logic [WordW-1:0] h_q, h_d;
  logic [WordW-1:0] k_q, k_d;
  logic [WordW-1:0] len_q, len_d;
  logic [NbW-1:0]   nb_q, nb_d;
  logic             last_q, last_d;
  logic             open_q, open_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] hash_q, hash_d;

  logic [NbW-1:0]   nb_in;
  logic [WordW-1:0] mul_a, mul_b, prod;
  logic [WordW-1:0] hx, hrot, hfull, hmix, len_sum;

  always_comb begin
    if (!last_word_i || (valid_bytes_i inside {[3'd5:3'd7]})) begin
      nb_in = NbFull;
    end else begin
      nb_in = valid_bytes_i;
    end
  end

  // One shared multiplier serves the block scramble and both finaliser steps.
  always_comb begin
    if (cmd_i.scramble) begin
      mul_a = rotl32(k_q, MixRotK);
      mul_b = MixC2;
    end else if (cmd_i.fin1) begin
      mul_a = h_q ^ (h_q >> 16);
      mul_b = FinM1;
    end else if (cmd_i.fin2) begin
      mul_a = h_q ^ (h_q >> 13);
      mul_b = FinM2;
    end else begin
      mul_a = data_word_i & tail_mask(nb_in);
      mul_b = MixC1;
    end
  end

  assign prod = mul_a * mul_b;

  assign hx      = h_q ^ k_q;
  assign hrot    = rotl32(hx, MixRotH);
  assign hfull   = (hrot << 2) + hrot + MixAddH;
  assign len_sum = len_q + {{(WordW-NbW){1'b0}}, nb_q};

  always_comb begin
    if (nb_q == NbFull) begin
      hmix = hfull;
    end else if (nb_q != '0) begin
      hmix = hx;
    end else begin
      hmix = h_q;
    end
  end

  always_comb begin
    h_d         = h_q;
    k_d         = k_q;
    len_d       = len_q;
    nb_d        = nb_q;
    last_d      = last_q;
    open_d      = open_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;

    if (cmd_i.load) begin
      k_d    = prod;
      nb_d   = nb_in;
      last_d = last_word_i;
      open_d = 1'b1;
      if (!open_q) begin
        h_d   = seed_i;
        len_d = '0;
      end
    end
    if (cmd_i.scramble) begin
      k_d = prod;
    end
    if (cmd_i.mix) begin
      len_d = len_sum;
      if (last_q) begin
        h_d    = hmix ^ len_sum;
        open_d = 1'b0;
      end else begin
        h_d = hmix;
      end
    end
    if (cmd_i.fin1 || cmd_i.fin2) begin
      h_d = prod;
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      hash_d      = h_q ^ (h_q >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    k_q    <= k_d;
    len_q  <= len_d;
    nb_q   <= nb_d;
    last_q <= last_d;
    hash_q <= hash_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = hash_q;

  a_last_mix_closes_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mix && last_q) |=> !open_q)
    else $error("key still open after mixing its last word");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("result register not loaded after emit");

endmodule

// ----- hw/rtl/m3sh_ctrl.sv -----
module m3sh_ctrl
  import m3sh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  m3sh_status_t status_i,
  output m3sh_cmd_t    cmd_o
);

  m3sh_state_e state_q, state_d;
  logic        accept;

  always_comb begin
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MIX:  in_ready_o = !status_i.last;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCRAM;
        end
      end
      ST_SCRAM: begin
        cmd_o.scramble = 1'b1;
        state_d        = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        if (status_i.last) begin
          state_d = ST_FIN1;
        end else if (accept) begin
          state_d = ST_SCRAM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_then_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> ##1 cmd_o.mix)
    else $error("accepted word was not mixed two cycles later");

  a_emit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !status_i.out_busy)
    else $error("result overwritten while still waiting");

  a_last_finalises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX && status_i.last) |=> (state_q == ST_FIN1))
    else $error("last word did not start finalisation");

endmodule
